### rtl/enr_pkg.sv
// enr_pkg: shared constants, codes and types for the event notification ring.
// Used by every module of the block; depends on nothing.
package enr_pkg;

    localparam int RING_DEPTH = 2048;
    localparam int PORT_WORDS = 32;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int IDX_W      = SLOT_W + 1;
    localparam int CNT_W      = 12;
    localparam int WORD_W     = $clog2(PORT_WORDS);
    localparam int PORT_W     = 10;
    localparam int ENTRY_W    = PORT_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ACT_UPCALL = 3'd0,
        ACT_ACK    = 3'd1,
        ACT_POP    = 3'd2,
        ACT_RESET  = 3'd3,
        ACT_CLOSE  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_OVF_ERR  = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_CLOSED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_MASK   = 2'd1,
        CMD_UNMASK = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_UPCALL,
        OP_ACK,
        OP_POP,
        OP_OTHER
    } op_t;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        op_t               op;
        logic              rebuild;
        logic              close;
        logic [PORT_W-1:0] port;
        logic              exc;
    } cmd_item_t;

    typedef enum logic [1:0] {
        BE_RUN,
        BE_SCAN_EXC,
        BE_SCAN_NRM,
        BE_POP_WAIT
    } be_state_t;

endpackage

### rtl/enr_front.sv
// enr_front: accepts input transfers, classifies them, and queues them for the back end.
// Depends on enr_pkg.
module enr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_action,
    input  logic [enr_pkg::PORT_W-1:0]    s_port,
    input  logic                          s_exception,
    output logic                          q_valid,
    input  logic                          q_ready,
    output enr_pkg::cmd_item_t            q_item
);

    enr_pkg::cmd_item_t                 slot_reg [enr_pkg::QUEUE_DEPTH];
    logic [enr_pkg::QIDX_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [enr_pkg::QIDX_W:0]           fill_reg;
    enr_pkg::cmd_item_t                 item;
    logic                               push, pop;

    always_comb begin
        item.port    = s_port;
        item.exc     = s_exception;
        item.rebuild = (s_action == enr_pkg::ACT_RESET);
        item.close   = (s_action == enr_pkg::ACT_CLOSE);
        case (s_action)
            enr_pkg::ACT_UPCALL: item.op = enr_pkg::OP_UPCALL;
            enr_pkg::ACT_ACK:    item.op = enr_pkg::OP_ACK;
            enr_pkg::ACT_POP:    item.op = enr_pkg::OP_POP;
            default:             item.op = enr_pkg::OP_OTHER;
        endcase
    end

    assign s_ready = (fill_reg != (enr_pkg::QIDX_W+1)'(enr_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= item;
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_reg + (enr_pkg::QIDX_W+1)'(push) - (enr_pkg::QIDX_W+1)'(pop);
        end
    end

endmodule

### rtl/enr_back.sv
// enr_back: executes queued commands against pending maps and the ring store.
// Depends on enr_pkg.
module enr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  enr_pkg::cmd_item_t            q_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [enr_pkg::PORT_W-1:0]    m_entry_port,
    output logic                          m_entry_exception,
    output logic                          m_wake,
    output logic [1:0]                    m_channel_cmd,
    output logic [enr_pkg::PORT_W-1:0]    m_cmd_port,
    output logic [enr_pkg::CNT_W-1:0]     m_waiting_count,
    output logic                          m_overflow_flag
);
    localparam int IW = enr_pkg::IDX_W;
    localparam int SW = enr_pkg::SLOT_W;
    localparam int WW = enr_pkg::WORD_W;
    localparam int PW = enr_pkg::PORT_W;

    logic [enr_pkg::ENTRY_W-1:0] ring_mem [enr_pkg::RING_DEPTH];
    logic [enr_pkg::ENTRY_W-1:0] rd_data_reg;

    logic [31:0] pend_n_reg [enr_pkg::PORT_WORDS];
    logic [31:0] pend_e_reg [enr_pkg::PORT_WORDS];

    logic [IW-1:0] rd_idx_reg, wr_idx_reg;
    logic          ovf_reg, open_reg;
    enr_pkg::be_state_t state_reg, state_next;
    logic [WW-1:0] word_reg;
    logic [31:0]   scan_reg;
    logic          scan_last_reg;

    // output register
    logic          ov_reg;
    logic [2:0]    o_status_reg;
    logic [PW-1:0] o_eport_reg, o_cport_reg;
    logic          o_eexc_reg, o_wake_reg, o_ovf_reg;
    logic [1:0]    o_cmd_reg;
    logic [enr_pkg::CNT_W-1:0] o_cnt_reg;

    logic [IW-1:0] count, wr_inc, rd_inc;
    logic          full, out_free, take;
    logic [WW-1:0] cmd_word;
    logic          word_ok;
    logic [4:0]    bitpos;
    logic [31:0]   lowbit;
    logic [4:0]    lowpos;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        logic [IW-1:0] n;
        n = i + 1'b1;
        return (n == IW'(2 * enr_pkg::RING_DEPTH)) ? '0 : n;
    endfunction

    function automatic logic [SW-1:0] slot(input logic [IW-1:0] i);
        return (i >= IW'(enr_pkg::RING_DEPTH)) ? SW'(i - IW'(enr_pkg::RING_DEPTH)) : SW'(i);
    endfunction

    assign count   = (wr_idx_reg >= rd_idx_reg) ? wr_idx_reg - rd_idx_reg
                   : wr_idx_reg + IW'(2 * enr_pkg::RING_DEPTH) - rd_idx_reg;
    assign full    = (count >= IW'(enr_pkg::RING_DEPTH));
    assign wr_inc  = idx_inc(wr_idx_reg);
    assign rd_inc  = idx_inc(rd_idx_reg);
    assign out_free = !ov_reg || m_ready;
    assign cmd_word = WW'(q_item.port >> 5);
    assign word_ok  = ((q_item.port >> 5) < PW'(enr_pkg::PORT_WORDS));
    assign bitpos   = q_item.port[4:0];
    assign lowbit   = scan_reg & (~scan_reg + 32'd1);

    always_comb begin
        lowpos = '0;
        for (int i = 0; i < 32; i++)
            if (lowbit[i]) lowpos = 5'(i);
    end

    assign q_ready = (state_reg == enr_pkg::BE_RUN) && out_free;
    assign take    = q_valid && q_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            enr_pkg::BE_RUN: begin
                if (take && q_item.op == enr_pkg::OP_POP && open_reg
                    && rd_idx_reg != wr_idx_reg)
                    state_next = enr_pkg::BE_POP_WAIT;
                else if (take && q_item.rebuild)
                    state_next = enr_pkg::BE_SCAN_EXC;
            end
            enr_pkg::BE_POP_WAIT: state_next = enr_pkg::BE_RUN;
            enr_pkg::BE_SCAN_EXC: if (scan_reg == '0) state_next = enr_pkg::BE_SCAN_NRM;
            enr_pkg::BE_SCAN_NRM: begin
                if (scan_reg == '0)
                    state_next = scan_last_reg ? (out_free ? enr_pkg::BE_RUN
                                                           : enr_pkg::BE_SCAN_NRM)
                                               : enr_pkg::BE_SCAN_EXC;
            end
            default: state_next = enr_pkg::BE_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= enr_pkg::BE_RUN;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            ovf_reg    <= 1'b0;
            open_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            word_reg   <= '0;
            scan_reg   <= '0;
            scan_last_reg <= 1'b0;
            for (int i = 0; i < enr_pkg::PORT_WORDS; i++) begin
                pend_n_reg[i] <= '0;
                pend_e_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            case (state_reg)
                enr_pkg::BE_RUN: if (take) begin
                    o_status_reg <= enr_pkg::ST_OK;
                    o_eport_reg  <= '0;
                    o_eexc_reg   <= 1'b0;
                    o_wake_reg   <= 1'b0;
                    o_cmd_reg    <= enr_pkg::CMD_NONE;
                    o_cport_reg  <= '0;
                    o_cnt_reg    <= enr_pkg::CNT_W'(count);
                    o_ovf_reg    <= ovf_reg;
                    ov_reg       <= 1'b1;
                    case (q_item.op)
                        enr_pkg::OP_UPCALL: begin
                            if (word_ok) begin
                                if (q_item.exc) pend_e_reg[cmd_word][bitpos] <= 1'b1;
                                else            pend_n_reg[cmd_word][bitpos] <= 1'b1;
                            end
                            o_cmd_reg   <= enr_pkg::CMD_MASK;
                            o_cport_reg <= q_item.port;
                            if (!open_reg) o_status_reg <= enr_pkg::ST_CLOSED;
                            else if (full) begin
                                ovf_reg      <= 1'b1;
                                o_ovf_reg    <= 1'b1;
                                o_status_reg <= enr_pkg::ST_DROPPED;
                            end else begin
                                o_wake_reg <= (rd_idx_reg == wr_idx_reg);
                                wr_idx_reg <= wr_inc;
                                o_cnt_reg  <= enr_pkg::CNT_W'(count + 1'b1);
                            end
                        end
                        enr_pkg::OP_ACK: begin
                            if (word_ok) begin
                                if (q_item.exc) pend_e_reg[cmd_word][bitpos] <= 1'b0;
                                else            pend_n_reg[cmd_word][bitpos] <= 1'b0;
                            end
                            o_cmd_reg   <= enr_pkg::CMD_UNMASK;
                            o_cport_reg <= q_item.port;
                        end
                        enr_pkg::OP_POP: begin
                            if (!open_reg) o_status_reg <= enr_pkg::ST_CLOSED;
                            else if (rd_idx_reg != wr_idx_reg) begin
                                // entry fields arrive next cycle from the RAM
                                ov_reg     <= 1'b0;
                                rd_idx_reg <= rd_inc;
                                o_cnt_reg  <= enr_pkg::CNT_W'(count - 1'b1);
                            end else if (ovf_reg) o_status_reg <= enr_pkg::ST_OVF_ERR;
                            else o_status_reg <= enr_pkg::ST_EMPTY;
                        end
                        default: begin
                            if (q_item.close) open_reg <= 1'b0;
                            if (q_item.rebuild) begin
                                ov_reg        <= 1'b0;
                                rd_idx_reg    <= '0;
                                wr_idx_reg    <= '0;
                                ovf_reg       <= 1'b0;
                                open_reg      <= 1'b1;
                                word_reg      <= '0;
                                scan_reg      <= pend_e_reg[0];
                                scan_last_reg <= (enr_pkg::PORT_WORDS == 1);
                            end
                        end
                    endcase
                end
                enr_pkg::BE_POP_WAIT: begin
                    o_eport_reg <= rd_data_reg[PW-1:0];
                    o_eexc_reg  <= rd_data_reg[PW];
                    ov_reg      <= 1'b1;
                end
                enr_pkg::BE_SCAN_EXC, enr_pkg::BE_SCAN_NRM: begin
                    if (scan_reg != '0) begin
                        scan_reg <= scan_reg & ~lowbit;
                        if (full) ovf_reg <= 1'b1;
                        else wr_idx_reg <= wr_inc;
                    end else if (state_reg == enr_pkg::BE_SCAN_EXC) begin
                        scan_reg <= pend_n_reg[word_reg];
                    end else if (!scan_last_reg) begin
                        word_reg      <= word_reg + 1'b1;
                        scan_reg      <= pend_e_reg[word_reg + 1'b1];
                        scan_last_reg <= ((word_reg + 1'b1) == WW'(enr_pkg::PORT_WORDS - 1));
                    end else if (out_free) begin
                        o_status_reg <= enr_pkg::ST_OK;
                        o_eport_reg  <= '0;
                        o_eexc_reg   <= 1'b0;
                        o_wake_reg   <= 1'b0;
                        o_cmd_reg    <= enr_pkg::CMD_NONE;
                        o_cport_reg  <= '0;
                        o_cnt_reg    <= enr_pkg::CNT_W'(count);
                        o_ovf_reg    <= ovf_reg;
                        ov_reg       <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (state_reg == enr_pkg::BE_RUN && take && q_item.op == enr_pkg::OP_UPCALL
            && open_reg && !full)
            ring_mem[slot(wr_idx_reg)] <= {q_item.exc, q_item.port};
        else if ((state_reg == enr_pkg::BE_SCAN_EXC || state_reg == enr_pkg::BE_SCAN_NRM)
                 && scan_reg != '0 && !full)
            ring_mem[slot(wr_idx_reg)] <=
                {state_reg == enr_pkg::BE_SCAN_EXC, PW'({word_reg, lowpos})};
        rd_data_reg <= ring_mem[slot(rd_idx_reg)];
    end

    assign m_valid           = ov_reg;
    assign m_status          = o_status_reg;
    assign m_entry_port      = o_eport_reg;
    assign m_entry_exception = o_eexc_reg;
    assign m_wake            = o_wake_reg;
    assign m_channel_cmd     = o_cmd_reg;
    assign m_cmd_port        = o_cport_reg;
    assign m_waiting_count   = o_cnt_reg;
    assign m_overflow_flag   = o_ovf_reg;

endmodule

### rtl/event_notification_ring.sv
// event_notification_ring: top level, joins the command front end and the ring back end.
// Depends on enr_pkg, enr_front, enr_back.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_action s_port s_exception
//  m_      | out       | m_valid m_ready m_status m_entry_port m_entry_exception m_wake
//          |           | m_channel_cmd m_cmd_port m_waiting_count m_overflow_flag
//
// Upcall, ack, close: done without leaving BE_RUN, so up to one transfer every cycle while m_ready holds.
// Pop with an entry waiting: passes through BE_POP_WAIT (registered ring RAM read).
// Reset-and-rebuild: the map scan walks each word's exception map, then its normal
// map, pushing one pending bit per cycle.
// aresetn clears the maps, indices, flags and queues; the ring RAM itself is not cleared.
// A stalled m_ fills the two-entry command queue, after which s_ready drops.
module event_notification_ring (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [9:0]  s_port,
    input  logic        s_exception,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [9:0]  m_entry_port,
    output logic        m_entry_exception,
    output logic        m_wake,
    output logic [1:0]  m_channel_cmd,
    output logic [9:0]  m_cmd_port,
    output logic [11:0] m_waiting_count,
    output logic        m_overflow_flag
);

    logic               q_valid, q_ready;
    enr_pkg::cmd_item_t q_item;

    // front end: classify and queue
    enr_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action, .s_port, .s_exception,
        .q_valid, .q_ready, .q_item
    );

    // back end: maps, ring, result register
    enr_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .m_valid, .m_ready, .m_status, .m_entry_port, .m_entry_exception, .m_wake,
        .m_channel_cmd, .m_cmd_port, .m_waiting_count, .m_overflow_flag
    );

endmodule

### rtl/enr_checker.sv
// enr_checker: port-level assertions for event_notification_ring, bound to the top level.
// Depends on enr_pkg.
module enr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [9:0]  m_entry_port,
    input logic        m_wake,
    input logic [1:0]  m_channel_cmd,
    input logic [9:0]  m_cmd_port,
    input logic [11:0] m_waiting_count
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_waiting_count))
        else $error("result changed while stalled");

    a_wake_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wake |-> m_waiting_count == 12'd1 && m_status == enr_pkg::ST_OK)
        else $error("wake without single entry");

    a_cmd_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_channel_cmd == enr_pkg::CMD_NONE |-> m_cmd_port == '0)
        else $error("cmd_port set without command");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_waiting_count <= 12'(enr_pkg::RING_DEPTH))
        else $error("count above ring depth");

    a_empty_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != enr_pkg::ST_OK |-> m_entry_port == '0)
        else $error("entry port on failed pop");

endmodule

bind event_notification_ring enr_checker u_enr_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_status, .m_entry_port, .m_wake,
    .m_channel_cmd, .m_cmd_port, .m_waiting_count
);
